// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file phi2_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is asserted.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/phi2_pkg.sv =====
// Package with register addresses, reset values and the Phi_2 constants.
package phi2_pkg;

    // Default field width of the modulus.
    localparam int unsigned MODULUS_WIDTH_DEF = 64;

    // Configuration port.
    localparam int unsigned ADDR_BITS = 4;
    localparam logic [ADDR_BITS-1:0] ADDR_PRIME  = 4'h0;
    localparam logic [ADDR_BITS-1:0] ADDR_NONRES = 4'h8;

    // Register reset values before masking to the modulus width.
    localparam logic [63:0] RESET_PRIME  = 64'd2305843009213693951;
    localparam logic [63:0] RESET_NONRES = 64'd2305843009213693950;

    // Integer constants of the specialized modular polynomial.
    localparam int unsigned CONST_BITS = 48;
    localparam logic [CONST_BITS-1:0] K_1488      = 48'd1488;
    localparam logic [CONST_BITS-1:0] K_162000    = 48'd162000;
    localparam logic [CONST_BITS-1:0] K_40773375  = 48'd40773375;
    localparam logic [CONST_BITS-1:0] K_8748E6    = 48'd8748000000;
    localparam logic [CONST_BITS-1:0] K_157464E9  = 48'd157464000000000;

endpackage

// ===== rtl/phi2_coefficients_fp2.sv =====
// Top level: coefficients of Phi_2(j,Y) over F_p^2, fully pipelined.
// Throughput is one request per cycle while the output is not stalled; four chained passes of the
// bit-serial modular multipliers, one multiplier bit per stage, set the depth.
// A stalled result holds the whole pipeline in place without loss.
// Reset clears all valid bits and loads the default modulus and nonresidue.
module phi2_coefficients_fp2 import phi2_pkg::*; #(
    parameter int unsigned MODULUS_WIDTH = MODULUS_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [63:0]          i_j_re,
    input  logic [63:0]          i_j_im,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [63:0]          o_c2_re,
    output logic [63:0]          o_c2_im,
    output logic [63:0]          o_c1_re,
    output logic [63:0]          o_c1_im,
    output logic [63:0]          o_c0_re,
    output logic [63:0]          o_c0_im,
    output logic                 o_out_of_range
);

    localparam int unsigned W  = MODULUS_WIDTH;
    localparam int unsigned M  = (W > CONST_BITS) ? W : CONST_BITS;
    localparam int unsigned NV = 4 * M + 5;

    typedef struct packed {
        logic [W-1:0] a;
        logic [W-1:0] c;
        logic [W-1:0] d;
        logic [W-1:0] j2_re;
        logic [W-1:0] j2_im;
        logic [W-1:0] j2k1488_re;
        logic [W-1:0] j2k1488_im;
        logic [W-1:0] j2k162_re;
        logic [W-1:0] j2k162_im;
        logic [W-1:0] jk1488_re;
        logic [W-1:0] jk1488_im;
        logic [W-1:0] jk4077_re;
        logic [W-1:0] jk4077_im;
        logic [W-1:0] jk8748_re;
        logic [W-1:0] jk8748_im;
        logic [W-1:0] k162;
        logic [W-1:0] k8748;
        logic [W-1:0] k157;
    } t_side_e;

    function automatic logic [W-1:0] f_add(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] p);
        logic [W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, p}) begin
            s = s - {1'b0, p};
        end
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] f_sub(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] p);
        logic [W-1:0] s;
        s = x - y;
        if (x < y) begin
            s = s + p;
        end
        return s;
    endfunction

    logic [W-1:0] r_p;
    logic [W-1:0] r_q;
    logic         en;
    logic [W-1:0] one;
    logic         in_oor;

    logic [NV-1:0] r_vld;
    logic [W-1:0]  r_s0_re;
    logic [W-1:0]  r_s0_im;
    logic          r_s0_oor;

    logic [W-1:0] m_rr, m_ii, m_ri, m_iiq;
    logic [W-1:0] a_re, a_im;
    logic [W-1:0] b_rr, b_ri, b_re, b_im;
    logic [W-1:0] r_c_j2re, r_c_j2im, r_c_re, r_c_im;
    logic [W-1:0] d_j2re, d_j2im;
    logic [W-1:0] m_b, m_bq;
    wire t_side_e side_d;
    t_side_e      side_e;
    logic         f3_oor;

    logic [W-1:0] r_f1_j3re, r_f1_j3im, r_f1_t2re, r_f1_t2im;
    logic [W-1:0] r_f1_u1re, r_f1_u1im, r_f1_wre, r_f1_wim;
    logic [W-1:0] r_f1_k162, r_f1_k8748, r_f1_k157;
    logic [W-1:0] r_f2_c2re, r_f2_c2im, r_f2_c1re, r_f2_c1im;
    logic [W-1:0] r_f2_x0re, r_f2_x0im, r_f2_k157;
    logic [W-1:0] r_f3_c2re, r_f3_c2im, r_f3_c1re, r_f3_c1im, r_f3_c0re, r_f3_c0im;
    logic         r_o_valid;

    // Configuration registers, masked to the modulus width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= RESET_PRIME[W-1:0];
            r_q <= RESET_NONRES[W-1:0];
        end else if (psel && penable && pwrite) begin
            if (paddr == ADDR_PRIME) begin
                r_p <= pwdata[W-1:0];
            end else if (paddr == ADDR_NONRES) begin
                r_q <= pwdata[W-1:0];
            end
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr)
            ADDR_PRIME:  prdata = 64'(r_p);
            ADDR_NONRES: prdata = 64'(r_q);
            default:     prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // The whole pipeline advances whenever the output register can take a result.
    assign en      = !r_o_valid || i_ready;
    assign o_ready = en;
    assign one     = {{(W-1){1'b0}}, (r_p > W'(1))};
    assign in_oor  = (i_j_re >= 64'(r_p)) || (i_j_im >= 64'(r_p));

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[NV-2:0], i_valid};
            r_o_valid <= r_vld[NV-1];
        end
    end

    // Input stage; an unreduced request is zeroed and flagged.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_re  <= in_oor ? '0 : i_j_re[W-1:0];
            r_s0_im  <= in_oor ? '0 : i_j_im[W-1:0];
            r_s0_oor <= in_oor;
        end
    end

    // First pass: products of the parts of j.
    phi2_mulmod #(.W(W), .NB(M)) u_rr (.i_clk(i_clk), .i_en(en), .i_p(r_p),
        .i_x(r_s0_re), .i_y(M'(r_s0_re)), .o_r(m_rr));
    phi2_mulmod #(.W(W), .NB(M)) u_ii (.i_clk(i_clk), .i_en(en), .i_p(r_p),
        .i_x(r_s0_im), .i_y(M'(r_s0_im)), .o_r(m_ii));
    phi2_mulmod #(.W(W), .NB(M)) u_ri (.i_clk(i_clk), .i_en(en), .i_p(r_p),
        .i_x(r_s0_re), .i_y(M'(r_s0_im)), .o_r(m_ri));
    phi2_dly #(.DW(2*W), .DEPTH(M)) u_dly_a (.i_clk(i_clk), .i_en(en),
        .i_d({r_s0_re, r_s0_im}), .o_d({a_re, a_im}));

    // Second pass: im^2 times the nonresidue.
    phi2_mulmod #(.W(W), .NB(M)) u_iiq (.i_clk(i_clk), .i_en(en), .i_p(r_p),
        .i_x(m_ii), .i_y(M'(r_q)), .o_r(m_iiq));
    phi2_dly #(.DW(4*W), .DEPTH(M)) u_dly_b (.i_clk(i_clk), .i_en(en),
        .i_d({m_rr, m_ri, a_re, a_im}), .o_d({b_rr, b_ri, b_re, b_im}));

    // Square of j.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_j2re <= f_add(b_rr, m_iiq, r_p);
            r_c_j2im <= f_add(b_ri, b_ri, r_p);
            r_c_re   <= b_re;
            r_c_im   <= b_im;
        end
    end

    // Third pass: cube products, constant scalings and reduced constants.
    phi2_mulmod #(.W(W), .NB(M)) u_a (.i_clk(i_clk), .i_en(en), .i_p(r_p),
        .i_x(r_c_j2re), .i_y(M'(r_c_re)), .o_r(side_d.a));
    phi2_mulmod #(.W(W), .NB(M)) u_b (.i_clk(i_clk), .i_en(en), .i_p(r_p),
        .i_x(r_c_j2im), .i_y(M'(r_c_im)), .o_r(m_b));
    phi2_mulmod #(.W(W), .NB(M)) u_c (.i_clk(i_clk), .i_en(en), .i_p(r_p),
        .i_x(r_c_j2re), .i_y(M'(r_c_im)), .o_r(side_d.c));
    phi2_mulmod #(.W(W), .NB(M)) u_d (.i_clk(i_clk), .i_en(en), .i_p(r_p),
        .i_x(r_c_j2im), .i_y(M'(r_c_re)), .o_r(side_d.d));
    phi2_mulmod #(.W(W), .NB(M)) u_j2k1488_re (.i_clk(i_clk), .i_en(en), .i_p(r_p),
        .i_x(r_c_j2re), .i_y(M'(K_1488)), .o_r(side_d.j2k1488_re));
    phi2_mulmod #(.W(W), .NB(M)) u_j2k1488_im (.i_clk(i_clk), .i_en(en), .i_p(r_p),
        .i_x(r_c_j2im), .i_y(M'(K_1488)), .o_r(side_d.j2k1488_im));
    phi2_mulmod #(.W(W), .NB(M)) u_j2k162_re (.i_clk(i_clk), .i_en(en), .i_p(r_p),
        .i_x(r_c_j2re), .i_y(M'(K_162000)), .o_r(side_d.j2k162_re));
    phi2_mulmod #(.W(W), .NB(M)) u_j2k162_im (.i_clk(i_clk), .i_en(en), .i_p(r_p),
        .i_x(r_c_j2im), .i_y(M'(K_162000)), .o_r(side_d.j2k162_im));
    phi2_mulmod #(.W(W), .NB(M)) u_jk1488_re (.i_clk(i_clk), .i_en(en), .i_p(r_p),
        .i_x(r_c_re), .i_y(M'(K_1488)), .o_r(side_d.jk1488_re));
    phi2_mulmod #(.W(W), .NB(M)) u_jk1488_im (.i_clk(i_clk), .i_en(en), .i_p(r_p),
        .i_x(r_c_im), .i_y(M'(K_1488)), .o_r(side_d.jk1488_im));
    phi2_mulmod #(.W(W), .NB(M)) u_jk4077_re (.i_clk(i_clk), .i_en(en), .i_p(r_p),
        .i_x(r_c_re), .i_y(M'(K_40773375)), .o_r(side_d.jk4077_re));
    phi2_mulmod #(.W(W), .NB(M)) u_jk4077_im (.i_clk(i_clk), .i_en(en), .i_p(r_p),
        .i_x(r_c_im), .i_y(M'(K_40773375)), .o_r(side_d.jk4077_im));
    phi2_mulmod #(.W(W), .NB(M)) u_jk8748_re (.i_clk(i_clk), .i_en(en), .i_p(r_p),
        .i_x(r_c_re), .i_y(M'(K_8748E6)), .o_r(side_d.jk8748_re));
    phi2_mulmod #(.W(W), .NB(M)) u_jk8748_im (.i_clk(i_clk), .i_en(en), .i_p(r_p),
        .i_x(r_c_im), .i_y(M'(K_8748E6)), .o_r(side_d.jk8748_im));
    phi2_mulmod #(.W(W), .NB(M)) u_k162 (.i_clk(i_clk), .i_en(en), .i_p(r_p),
        .i_x(one), .i_y(M'(K_162000)), .o_r(side_d.k162));
    phi2_mulmod #(.W(W), .NB(M)) u_k8748 (.i_clk(i_clk), .i_en(en), .i_p(r_p),
        .i_x(one), .i_y(M'(K_8748E6)), .o_r(side_d.k8748));
    phi2_mulmod #(.W(W), .NB(M)) u_k157 (.i_clk(i_clk), .i_en(en), .i_p(r_p),
        .i_x(one), .i_y(M'(K_157464E9)), .o_r(side_d.k157));
    phi2_dly #(.DW(2*W), .DEPTH(M)) u_dly_d (.i_clk(i_clk), .i_en(en),
        .i_d({r_c_j2re, r_c_j2im}), .o_d({d_j2re, d_j2im}));
    assign side_d.j2_re = d_j2re;
    assign side_d.j2_im = d_j2im;

    // Fourth pass: im part product times the nonresidue.
    phi2_mulmod #(.W(W), .NB(M)) u_bq (.i_clk(i_clk), .i_en(en), .i_p(r_p),
        .i_x(m_b), .i_y(M'(r_q)), .o_r(m_bq));
    phi2_dly #(.DW($bits(t_side_e)), .DEPTH(M)) u_dly_e (.i_clk(i_clk), .i_en(en),
        .i_d(side_d), .o_d(side_e));

    // Range flag rides along to the last combine stage.
    phi2_dly #(.DW(1), .DEPTH(4*M+4)) u_dly_oor (.i_clk(i_clk), .i_en(en),
        .i_d(r_s0_oor), .o_d(f3_oor));

    // Combine, first step: cube of j and partial sums.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_j3re  <= f_add(side_e.a, m_bq, r_p);
            r_f1_j3im  <= f_add(side_e.c, side_e.d, r_p);
            r_f1_t2re  <= f_sub(side_e.jk1488_re, side_e.j2_re, r_p);
            r_f1_t2im  <= f_sub(side_e.jk1488_im, side_e.j2_im, r_p);
            r_f1_u1re  <= f_add(side_e.j2k1488_re, side_e.jk4077_re, r_p);
            r_f1_u1im  <= f_add(side_e.j2k1488_im, side_e.jk4077_im, r_p);
            r_f1_wre   <= f_sub(side_e.jk8748_re, side_e.j2k162_re, r_p);
            r_f1_wim   <= f_sub(side_e.jk8748_im, side_e.j2k162_im, r_p);
            r_f1_k162  <= side_e.k162;
            r_f1_k8748 <= side_e.k8748;
            r_f1_k157  <= side_e.k157;
        end
    end

    // Combine, second step: c2 and c1 finish, c0 gathers its j terms.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f2_c2re <= f_sub(r_f1_t2re, r_f1_k162, r_p);
            r_f2_c2im <= r_f1_t2im;
            r_f2_c1re <= f_add(r_f1_u1re, r_f1_k8748, r_p);
            r_f2_c1im <= r_f1_u1im;
            r_f2_x0re <= f_add(r_f1_j3re, r_f1_wre, r_p);
            r_f2_x0im <= f_add(r_f1_j3im, r_f1_wim, r_p);
            r_f2_k157 <= r_f1_k157;
        end
    end

    // Combine, third step: constant term of c0.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f3_c2re <= r_f2_c2re;
            r_f3_c2im <= r_f2_c2im;
            r_f3_c1re <= r_f2_c1re;
            r_f3_c1im <= r_f2_c1im;
            r_f3_c0re <= f_sub(r_f2_x0re, r_f2_k157, r_p);
            r_f3_c0im <= r_f2_x0im;
        end
    end

    // Output register; a flagged request returns zeros.
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_c2_re        <= f3_oor ? '0 : 64'(r_f3_c2re);
            o_c2_im        <= f3_oor ? '0 : 64'(r_f3_c2im);
            o_c1_re        <= f3_oor ? '0 : 64'(r_f3_c1re);
            o_c1_im        <= f3_oor ? '0 : 64'(r_f3_c1im);
            o_c0_re        <= f3_oor ? '0 : 64'(r_f3_c0re);
            o_c0_im        <= f3_oor ? '0 : 64'(r_f3_c0im);
            o_out_of_range <= f3_oor;
        end
    end
    assign o_valid = r_o_valid;

endmodule

// ===== rtl/phi2_mulmod.sv =====
// Pipelined shift-and-add modular multiplier, one multiplier bit per stage.
module phi2_mulmod import phi2_pkg::*; #(
    parameter int unsigned W  = MODULUS_WIDTH_DEF,
    parameter int unsigned NB = CONST_BITS
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [W-1:0]  i_p,
    input  logic [W-1:0]  i_x,
    input  logic [NB-1:0] i_y,
    output logic [W-1:0]  o_r
);

    // One step: (2r + b*x) mod p, with r and x below p so the sum stays below 3p.
    function automatic logic [W-1:0] f_step(input logic [W-1:0] r, input logic [W-1:0] x,
                                            input logic b, input logic [W-1:0] p);
        logic [W+1:0] s;
        logic [W+1:0] p1;
        logic [W+1:0] p2;
        s  = {1'b0, r, 1'b0} + (b ? {2'b00, x} : '0);
        p1 = {2'b00, p};
        p2 = {1'b0, p, 1'b0};
        if (s >= p2) begin
            s = s - p2;
        end else if (s >= p1) begin
            s = s - p1;
        end
        return s[W-1:0];
    endfunction

    logic [W-1:0]  r_r [NB];
    logic [W-1:0]  r_x [NB-1];
    logic [NB-1:0] r_y [NB-1];

    // Stages walk the multiplier from its top bit down.
    for (genvar k = 0; k < NB; k++) begin : g_stage
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_r[0] <= f_step('0, i_x, i_y[NB-1], i_p);
                    r_x[0] <= i_x;
                    r_y[0] <= i_y;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_r[k] <= f_step(r_r[k-1], r_x[k-1], r_y[k-1][NB-1-k], i_p);
                end
            end
            if (k < NB - 1) begin : g_carry
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_x[k] <= r_x[k-1];
                        r_y[k] <= r_y[k-1];
                    end
                end
            end
        end
    end

    assign o_r = r_r[NB-1];

endmodule

// ===== rtl/phi2_dly.sv =====
// Stallable delay line that keeps operands aligned with the multiplier stages.
module phi2_dly import phi2_pkg::*; #(
    parameter int unsigned DW    = MODULUS_WIDTH_DEF,
    parameter int unsigned DEPTH = 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_d,
    output logic [DW-1:0] o_d
);

    logic [DW-1:0] r_d [DEPTH];

    // Shift one place on every pipeline advance.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_d[k] <= r_d[k-1];
            end
        end
    end

    assign o_d = r_d[DEPTH-1];

endmodule

// ===== rtl/phi2_chk.sv =====
// Port-level checker for the Phi_2 coefficient block, with its bind.
`include "assert_macros.svh"

module phi2_chk import phi2_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 psel,
    input logic                 penable,
    input logic                 pwrite,
    input logic [ADDR_BITS-1:0] paddr,
    input logic [63:0]          pwdata,
    input logic [63:0]          prdata,
    input logic                 pready,
    input logic                 i_valid,
    input logic                 o_ready,
    input logic [63:0]          i_j_re,
    input logic [63:0]          i_j_im,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [63:0]          o_c2_re,
    input logic [63:0]          o_c2_im,
    input logic [63:0]          o_c1_re,
    input logic [63:0]          o_c1_im,
    input logic [63:0]          o_c0_re,
    input logic [63:0]          o_c0_im,
    input logic                 o_out_of_range
);

    // A stalled result stays valid and holds its c0 and c2 real parts.
    `ASSERT_PROP(a_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_c0_re) && $stable(o_c2_re), "stalled result changed")

    // A flagged result carries only zero coefficients.
    `ASSERT_PROP(a_oor_zero, i_clk, i_rst_n, o_valid && o_out_of_range |-> (o_c2_re == 64'd0) && (o_c2_im == 64'd0) && (o_c1_re == 64'd0) && (o_c1_im == 64'd0) && (o_c0_re == 64'd0) && (o_c0_im == 64'd0), "flagged result not zero")

    // The pipeline takes requests exactly when the output slot frees up.
    `ASSERT_PROP(a_ready, i_clk, i_rst_n, o_ready == (!o_valid || i_ready), "ready does not follow output slot")

    // Reset empties the output.
    `ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind phi2_coefficients_fp2 phi2_chk u_phi2_chk (.*);
